// File: rtl/iorf_pkg.sv
// ----------------------------------------------------------------------------
// iorf_pkg
// Types, address map and byte-lane helpers of the I/O register block.
// ----------------------------------------------------------------------------
package iorf_pkg;

  localparam int unsigned AddrW    = 32;
  localparam int unsigned ButtonW  = 10;
  localparam int unsigned IrqW     = 16;
  localparam int unsigned ChanMax  = 4;
  localparam int unsigned ChanIdxW = 2;

  localparam logic [31:0] IO_BASE      = 32'h0400_0000;
  localparam logic [31:0] OFF_DMA_LO   = 32'h0000_00B0;
  localparam logic [31:0] OFF_DMA_HI   = 32'h0000_00E0;
  localparam logic [31:0] OFF_TMR_LO   = 32'h0000_0100;
  localparam logic [31:0] OFF_TMR_HI   = 32'h0000_0110;
  localparam logic [31:0] OFF_KEYIN_0  = 32'h0000_0130;
  localparam logic [31:0] OFF_KEYIN_1  = 32'h0000_0131;
  localparam logic [31:0] OFF_KEYCTL_0 = 32'h0000_0132;
  localparam logic [31:0] OFF_KEYCTL_1 = 32'h0000_0133;
  localparam logic [31:0] OFF_IE_0     = 32'h0000_0200;
  localparam logic [31:0] OFF_IE_1     = 32'h0000_0201;
  localparam logic [31:0] OFF_IF_0     = 32'h0000_0202;
  localparam logic [31:0] OFF_IF_1     = 32'h0000_0203;
  localparam logic [31:0] OFF_WAIT_0   = 32'h0000_0204;
  localparam logic [31:0] OFF_WAIT_1   = 32'h0000_0205;
  localparam logic [31:0] OFF_IME      = 32'h0000_0208;
  localparam logic [31:0] OFF_POST     = 32'h0000_0300;
  localparam logic [31:0] OFF_HALT     = 32'h0000_0301;
  localparam logic [31:0] OFF_MEMCTL_0 = 32'h0000_0800;
  localparam logic [31:0] OFF_MEMCTL_1 = 32'h0000_0801;
  localparam logic [31:0] OFF_MEMCTL_2 = 32'h0000_0802;
  localparam logic [31:0] OFF_MEMCTL_3 = 32'h0000_0803;

  localparam logic [5:0]  DMA_STRIDE   = 6'd12;
  localparam logic [7:0]  KEY_UPDOWN   = 8'hC0;
  localparam logic [7:0]  KEY_LEFTRIGHT = 8'h30;
  localparam logic [15:0] WAIT_MASK    = 16'h7FFF;
  localparam logic [7:0]  HALT_STOP_BIT = 8'h80;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_HALT = 2'd1,
    MODE_STOP = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    DMA_SRC = 2'd0,
    DMA_TGT = 2'd1,
    DMA_LEN = 2'd2,
    DMA_CTL = 2'd3
  } dma_reg_e;

  typedef enum logic [3:0] {
    SEL_NONE   = 4'd0,
    SEL_KEYIN  = 4'd1,
    SEL_KEYCTL = 4'd2,
    SEL_IE     = 4'd3,
    SEL_IF     = 4'd4,
    SEL_WAIT   = 4'd5,
    SEL_IME    = 4'd6,
    SEL_POST   = 4'd7,
    SEL_HALT   = 4'd8,
    SEL_MEMCTL = 4'd9
  } sel_e;

  typedef struct packed {
    logic                op;
    logic [AddrW-1:0]    address;
    logic [7:0]          write_data;
    logic [ButtonW-1:0]  buttons;
    logic [IrqW-1:0]     irq_set;
  } in_t;

  typedef struct packed {
    logic [7:0]          read_data;
    logic [1:0]          cpu_mode_request;
    logic [ChanMax-1:0]  dma_started;
    logic [ChanMax-1:0]  timer_started;
  } res_t;

  typedef struct packed {
    logic                dma_hit;
    logic [ChanIdxW-1:0] dma_ch;
    dma_reg_e            dma_reg;
    logic                tmr_hit;
    logic [ChanIdxW-1:0] tmr_idx;
    logic                tmr_ctl;
    sel_e                sel;
    logic [1:0]          byte_idx;
    logic                lane;
  } dec_t;

  function automatic logic [31:0] put_byte32(logic [31:0] v, logic [1:0] idx,
                                             logic [7:0] b);
    logic [31:0] r;
    r = v;
    r[idx*8 +: 8] = b;
    return r;
  endfunction

  function automatic logic [15:0] put_byte16(logic [15:0] v, logic lane, logic [7:0] b);
    logic [15:0] r;
    r = v;
    r[lane*8 +: 8] = b;
    return r;
  endfunction

  function automatic logic [7:0] get_byte16(logic [15:0] v, logic lane);
    return v[lane*8 +: 8];
  endfunction

  function automatic logic [7:0] get_byte32(logic [31:0] v, logic [1:0] idx);
    return v[idx*8 +: 8];
  endfunction

endpackage

// File: rtl/iorf_if.sv
// ----------------------------------------------------------------------------
// iorf_in_if / iorf_out_if
// Valid/ready channels carrying bus access words and result words.
// ----------------------------------------------------------------------------
interface iorf_in_if;
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [iorf_pkg::AddrW-1:0]   address;
  logic [7:0]                   write_data;
  logic [iorf_pkg::ButtonW-1:0] buttons;
  logic [iorf_pkg::IrqW-1:0]    irq_set;

  modport source (output valid, op, address, write_data, buttons, irq_set, input ready);
  modport sink   (input valid, op, address, write_data, buttons, irq_set, output ready);
endinterface

interface iorf_out_if;
  logic                         valid;
  logic                         ready;
  logic [7:0]                   read_data;
  logic [1:0]                   cpu_mode_request;
  logic [iorf_pkg::ChanMax-1:0] dma_started;
  logic [iorf_pkg::ChanMax-1:0] timer_started;

  modport source (output valid, read_data, cpu_mode_request, dma_started, timer_started,
                  input ready);
  modport sink   (input valid, read_data, cpu_mode_request, dma_started, timer_started,
                  output ready);
endinterface

// File: rtl/iorf_decode.sv
// ----------------------------------------------------------------------------
// iorf_decode
// Address decode: register region, channel, register and byte lane.
// ----------------------------------------------------------------------------
module iorf_decode (
  input  logic [iorf_pkg::AddrW-1:0] address_i,
  output iorf_pkg::dec_t             dec_o
);

  logic [31:0]                    off;
  logic [5:0]                     rel;
  logic [iorf_pkg::ChanIdxW-1:0]  ch;
  logic [5:0]                     r;

  assign off = address_i - iorf_pkg::IO_BASE;
  assign rel = 6'(off[7:0] - iorf_pkg::OFF_DMA_LO[7:0]);

  always_comb begin
    if (rel >= 6'(iorf_pkg::DMA_STRIDE * 6'd3)) begin
      ch = 2'd3;
    end else if (rel >= 6'(iorf_pkg::DMA_STRIDE * 6'd2)) begin
      ch = 2'd2;
    end else if (rel >= iorf_pkg::DMA_STRIDE) begin
      ch = 2'd1;
    end else begin
      ch = 2'd0;
    end
  end

  assign r = 6'(rel - iorf_pkg::DMA_STRIDE * {4'd0, ch});

  always_comb begin
    dec_o          = '0;
    dec_o.dma_hit  = (off >= iorf_pkg::OFF_DMA_LO) && (off < iorf_pkg::OFF_DMA_HI);
    dec_o.dma_ch   = ch;
    if (r < 6'd4) begin
      dec_o.dma_reg = iorf_pkg::DMA_SRC;
    end else if (r < 6'd8) begin
      dec_o.dma_reg = iorf_pkg::DMA_TGT;
    end else if (r < 6'd10) begin
      dec_o.dma_reg = iorf_pkg::DMA_LEN;
    end else begin
      dec_o.dma_reg = iorf_pkg::DMA_CTL;
    end
    dec_o.tmr_hit  = (off >= iorf_pkg::OFF_TMR_LO) && (off < iorf_pkg::OFF_TMR_HI);
    dec_o.tmr_idx  = off[3:2];
    dec_o.tmr_ctl  = off[1];
    dec_o.byte_idx = off[1:0];
    dec_o.lane     = off[0];
    case (off)
      iorf_pkg::OFF_KEYIN_0,  iorf_pkg::OFF_KEYIN_1:  dec_o.sel = iorf_pkg::SEL_KEYIN;
      iorf_pkg::OFF_KEYCTL_0, iorf_pkg::OFF_KEYCTL_1: dec_o.sel = iorf_pkg::SEL_KEYCTL;
      iorf_pkg::OFF_IE_0,     iorf_pkg::OFF_IE_1:     dec_o.sel = iorf_pkg::SEL_IE;
      iorf_pkg::OFF_IF_0,     iorf_pkg::OFF_IF_1:     dec_o.sel = iorf_pkg::SEL_IF;
      iorf_pkg::OFF_WAIT_0,   iorf_pkg::OFF_WAIT_1:   dec_o.sel = iorf_pkg::SEL_WAIT;
      iorf_pkg::OFF_IME:                              dec_o.sel = iorf_pkg::SEL_IME;
      iorf_pkg::OFF_POST:                             dec_o.sel = iorf_pkg::SEL_POST;
      iorf_pkg::OFF_HALT:                             dec_o.sel = iorf_pkg::SEL_HALT;
      iorf_pkg::OFF_MEMCTL_0, iorf_pkg::OFF_MEMCTL_1,
      iorf_pkg::OFF_MEMCTL_2, iorf_pkg::OFF_MEMCTL_3: dec_o.sel = iorf_pkg::SEL_MEMCTL;
      default:                                        dec_o.sel = iorf_pkg::SEL_NONE;
    endcase
  end

endmodule

// File: rtl/iorf_regs.sv
// ----------------------------------------------------------------------------
// iorf_regs
// Register state, write update and read selection for one access word.
// ----------------------------------------------------------------------------
module iorf_regs #(
  parameter int unsigned DMA_CHANNELS = 4,
  parameter int unsigned TIMER_COUNT  = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  iorf_pkg::in_t       in_i,
  input  iorf_pkg::dec_t      dec_i,
  output iorf_pkg::res_t      res_o
);

  logic        wr;
  logic [7:0]  b;
  logic [7:0]  dma_rd   [DMA_CHANNELS];
  logic        dma_rise [DMA_CHANNELS];
  logic [7:0]  tmr_rd   [TIMER_COUNT];
  logic        tmr_rise [TIMER_COUNT];

  logic [15:0] keyctl_q, ie_q, if_q, wait_q;
  logic [15:0] if_d;
  logic        ime_q, post_q;
  logic [31:0] memctl_q;
  logic [7:0]  key_lo, key_rd, misc_rd, rd;
  logic [1:0]  mode;

  assign wr = (in_i.op == iorf_pkg::OP_WRITE);
  assign b  = in_i.write_data;

  for (genvar i = 0; i < DMA_CHANNELS; i++) begin : g_dma
    logic        sel, rise;
    logic [31:0] src_q, tgt_q, run_src_q, run_tgt_q;
    logic [15:0] len_q, ctl_q, run_len_q, ctl_new;

    assign sel     = dec_i.dma_hit && (dec_i.dma_ch == iorf_pkg::ChanIdxW'(i));
    assign ctl_new = iorf_pkg::put_byte16(ctl_q, dec_i.lane, b);
    assign rise    = sel && wr && (dec_i.dma_reg == iorf_pkg::DMA_CTL) &&
                     !ctl_q[15] && ctl_new[15];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        src_q     <= '0;
        tgt_q     <= '0;
        len_q     <= '0;
        ctl_q     <= '0;
        run_src_q <= '0;
        run_tgt_q <= '0;
        run_len_q <= '0;
      end else if (fire_i && sel && wr) begin
        case (dec_i.dma_reg)
          iorf_pkg::DMA_SRC: src_q <= iorf_pkg::put_byte32(src_q, dec_i.byte_idx, b);
          iorf_pkg::DMA_TGT: tgt_q <= iorf_pkg::put_byte32(tgt_q, dec_i.byte_idx, b);
          iorf_pkg::DMA_LEN: len_q <= iorf_pkg::put_byte16(len_q, dec_i.lane, b);
          iorf_pkg::DMA_CTL: begin
            ctl_q <= ctl_new;
            if (rise) begin
              run_src_q <= src_q;
              run_tgt_q <= tgt_q;
              run_len_q <= len_q;
            end
          end
          default: ;
        endcase
      end
    end

    assign dma_rd[i]   = (sel && (dec_i.dma_reg == iorf_pkg::DMA_CTL)) ?
                         iorf_pkg::get_byte16(ctl_q, dec_i.lane) : 8'd0;
    assign dma_rise[i] = rise;
  end

  for (genvar i = 0; i < TIMER_COUNT; i++) begin : g_tmr
    logic        sel, rise;
    logic [15:0] reload_q, count_q;
    logic [7:0]  ctl_q;

    assign sel  = dec_i.tmr_hit && (dec_i.tmr_idx == iorf_pkg::ChanIdxW'(i));
    assign rise = sel && wr && dec_i.tmr_ctl && !dec_i.lane && !ctl_q[7] && b[7];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        reload_q <= '0;
        count_q  <= '0;
        ctl_q    <= '0;
      end else if (fire_i && sel && wr) begin
        if (!dec_i.tmr_ctl) begin
          reload_q <= iorf_pkg::put_byte16(reload_q, dec_i.lane, b);
        end else if (!dec_i.lane) begin
          ctl_q <= b;
          if (rise) begin
            count_q <= reload_q;
          end
        end
      end
    end

    always_comb begin
      tmr_rd[i] = 8'd0;
      if (sel) begin
        if (!dec_i.tmr_ctl) begin
          tmr_rd[i] = iorf_pkg::get_byte16(count_q, dec_i.lane);
        end else if (!dec_i.lane) begin
          tmr_rd[i] = ctl_q;
        end
      end
    end
    assign tmr_rise[i] = rise;
  end

  always_comb begin
    key_lo = in_i.buttons[7:0];
    if ((key_lo & iorf_pkg::KEY_UPDOWN) == iorf_pkg::KEY_UPDOWN) begin
      key_lo = key_lo & ~iorf_pkg::KEY_UPDOWN;
    end
    if ((key_lo & iorf_pkg::KEY_LEFTRIGHT) == iorf_pkg::KEY_LEFTRIGHT) begin
      key_lo = key_lo & ~iorf_pkg::KEY_LEFTRIGHT;
    end
    key_rd = dec_i.lane ? ~{6'd0, in_i.buttons[9:8]} ^ 8'hFC : ~key_lo;
  end

  always_comb begin
    misc_rd = 8'd0;
    mode    = iorf_pkg::MODE_NONE;
    if_d    = if_q;
    case (dec_i.sel)
      iorf_pkg::SEL_KEYIN:  misc_rd = key_rd;
      iorf_pkg::SEL_KEYCTL: misc_rd = iorf_pkg::get_byte16(keyctl_q, dec_i.lane);
      iorf_pkg::SEL_IE:     misc_rd = iorf_pkg::get_byte16(ie_q, dec_i.lane);
      iorf_pkg::SEL_IF: begin
        misc_rd = iorf_pkg::get_byte16(if_q, dec_i.lane);
        if (wr) begin
          if_d = if_q & ~(16'(b) << (dec_i.lane ? 4'd8 : 4'd0));
        end
      end
      iorf_pkg::SEL_WAIT:   misc_rd = iorf_pkg::get_byte16(wait_q, dec_i.lane);
      iorf_pkg::SEL_IME:    misc_rd = {7'd0, ime_q};
      iorf_pkg::SEL_POST:   misc_rd = {7'd0, post_q};
      iorf_pkg::SEL_HALT: begin
        if (wr) begin
          mode = ((b & iorf_pkg::HALT_STOP_BIT) != 8'd0) ? iorf_pkg::MODE_STOP :
                                                           iorf_pkg::MODE_HALT;
        end
      end
      iorf_pkg::SEL_MEMCTL: misc_rd = iorf_pkg::get_byte32(memctl_q, dec_i.byte_idx);
      default: ;
    endcase
    if_d = if_d | in_i.irq_set;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keyctl_q <= '0;
      ie_q     <= '0;
      if_q     <= '0;
      wait_q   <= '0;
      ime_q    <= 1'b0;
      post_q   <= 1'b0;
      memctl_q <= '0;
    end else if (fire_i) begin
      if_q <= if_d;
      if (wr) begin
        case (dec_i.sel)
          iorf_pkg::SEL_KEYCTL: keyctl_q <= iorf_pkg::put_byte16(keyctl_q, dec_i.lane, b);
          iorf_pkg::SEL_IE:     ie_q     <= iorf_pkg::put_byte16(ie_q, dec_i.lane, b);
          iorf_pkg::SEL_WAIT:   wait_q   <= iorf_pkg::put_byte16(wait_q, dec_i.lane, b) &
                                            iorf_pkg::WAIT_MASK;
          iorf_pkg::SEL_IME:    ime_q    <= b[0];
          iorf_pkg::SEL_POST:   post_q   <= b[0];
          iorf_pkg::SEL_MEMCTL: memctl_q <= iorf_pkg::put_byte32(memctl_q, dec_i.byte_idx, b);
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    rd                  = misc_rd;
    res_o.dma_started   = '0;
    res_o.timer_started = '0;
    for (int i = 0; i < DMA_CHANNELS; i++) begin
      rd                   = rd | dma_rd[i];
      res_o.dma_started[i] = dma_rise[i];
    end
    for (int i = 0; i < TIMER_COUNT; i++) begin
      rd                     = rd | tmr_rd[i];
      res_o.timer_started[i] = tmr_rise[i];
    end
    res_o.read_data        = wr ? 8'd0 : rd;
    res_o.cpu_mode_request = mode;
  end

endmodule

// File: rtl/io_register_file_dma_timer_irq_unit.sv
// ----------------------------------------------------------------------------
// io_register_file_dma_timer_irq_unit
// Byte-wide memory-mapped I/O register block with DMA, timer and IRQ registers.
// ----------------------------------------------------------------------------
// One bus access word enters per clock and one result word leaves per clock,
// unless the output stalls. Each word passes the input register, where the
// address is decoded and the registers are read and updated, then the result
// register. The register update of one word is complete before the next
// word is decoded, so back-to-back accesses see each other's writes. The
// input side stays ready while a result waits, until both stages hold.
module io_register_file_dma_timer_irq_unit #(
  parameter int unsigned DMA_CHANNELS = 4,
  parameter int unsigned TIMER_COUNT  = 4
) (
  input logic        clk_i,
  input logic        rst_ni,
  iorf_in_if.sink    in_i,
  iorf_out_if.source out_o
);

  iorf_pkg::in_t  s_q;
  logic           s_valid_q;
  iorf_pkg::dec_t dec;
  iorf_pkg::res_t res, res_q;
  logic           out_valid_q;
  logic           advance;
  logic           in_ready;

  assign advance  = s_valid_q && (!out_valid_q || out_o.ready);
  assign in_ready = !s_valid_q || advance;
  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (in_ready) begin
      s_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      s_q.op         <= in_i.op;
      s_q.address    <= in_i.address;
      s_q.write_data <= in_i.write_data;
      s_q.buttons    <= in_i.buttons;
      s_q.irq_set    <= in_i.irq_set;
    end
  end

  iorf_decode u_decode (
    .address_i (s_q.address),
    .dec_o     (dec)
  );

  iorf_regs #(
    .DMA_CHANNELS (DMA_CHANNELS),
    .TIMER_COUNT  (TIMER_COUNT)
  ) u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .in_i   (s_q),
    .dec_i  (dec),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.read_data        = res_q.read_data;
  assign out_o.cpu_mode_request = res_q.cpu_mode_request;
  assign out_o.dma_started      = res_q.dma_started;
  assign out_o.timer_started    = res_q.timer_started;

endmodule

// File: rtl/iorf_chk.sv
// ----------------------------------------------------------------------------
// iorf_chk
// Port-level checks of the I/O register block, bound to the top level.
// ----------------------------------------------------------------------------
module iorf_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [7:0]                   read_data_i,
  input logic [1:0]                   cpu_mode_request_i,
  input logic [iorf_pkg::ChanMax-1:0] dma_started_i,
  input logic [iorf_pkg::ChanMax-1:0] timer_started_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(read_data_i) &&
    $stable(cpu_mode_request_i) && $stable(dma_started_i) && $stable(timer_started_i))
    else $error("result word changed while stalled");

  a_one_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> $onehot0(dma_started_i) && $onehot0(timer_started_i))
    else $error("one access started more than one channel or timer");

  a_read_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (read_data_i != 8'd0) |->
    (cpu_mode_request_i == iorf_pkg::MODE_NONE) && (dma_started_i == '0) &&
    (timer_started_i == '0))
    else $error("read word carries write side effects");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result word without an accepted access");

endmodule

bind io_register_file_dma_timer_irq_unit iorf_chk u_iorf_chk (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_i.valid),
  .in_ready_i         (in_i.ready),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .read_data_i        (out_o.read_data),
  .cpu_mode_request_i (out_o.cpu_mode_request),
  .dma_started_i      (out_o.dma_started),
  .timer_started_i    (out_o.timer_started)
);
